// ----- design/ascal_pkg.sv -----
// Shared types and constants for the averaged sensor calibration block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ascal_pkg;

    localparam int SAMPLE_COUNT_LOG2_DEF = 3;
    localparam int COEF_FRAC_BITS_DEF    = 13;

    localparam int AXIS_W = 16;
    localparam int REG_W  = 3 * AXIS_W;
    localparam int DIFF_W = AXIS_W + 1;
    localparam int PROD_W = DIFF_W + AXIS_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int CFG_IDX_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [REG_W-1:0] ROW0_RST   = 48'h0000_0000_2000;
    localparam logic [REG_W-1:0] ROW1_RST   = 48'h0000_2000_0000;
    localparam logic [REG_W-1:0] ROW2_RST   = 48'h2000_0000_0000;
    localparam logic [REG_W-1:0] OFFSET_RST = 48'h0000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0   = 3'd0,
        CFG_ROW1   = 3'd1,
        CFG_ROW2   = 3'd2,
        CFG_OFFSET = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [AXIS_W-1:0] z;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] x;
    } t_vec;

    typedef logic [2:0][REG_W-1:0] t_mat;

endpackage

// ----- design/ascal_front.sv -----
// Front end: accumulates raw samples per axis and emits the floored mean.
// Depends on ascal_pkg.
`timescale 1ns / 1ps
module ascal_front import ascal_pkg::*; #(
    parameter int SAMPLE_COUNT_LOG2 = SAMPLE_COUNT_LOG2_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_ready,
    input  t_vec i_raw,
    output logic o_push,
    output t_vec o_mean
);

    localparam int ACC_W = AXIS_W + SAMPLE_COUNT_LOG2;
    localparam int CNT_W = (SAMPLE_COUNT_LOG2 > 0) ? SAMPLE_COUNT_LOG2 : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'((1 << SAMPLE_COUNT_LOG2) - 1);

    logic signed [ACC_W-1:0] r_sum [3];
    logic signed [ACC_W-1:0] n_sum [3];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic w_acc;
    logic w_last;

    assign w_acc  = i_valid && i_ready;
    assign w_last = (r_cnt == CNT_LAST);
    assign o_push = w_acc && w_last;

    always_comb begin
        n_sum[0] = r_sum[0] + ACC_W'(i_raw.x);
        n_sum[1] = r_sum[1] + ACC_W'(i_raw.y);
        n_sum[2] = r_sum[2] + ACC_W'(i_raw.z);
        o_mean.x = AXIS_W'(n_sum[0] >>> SAMPLE_COUNT_LOG2);
        o_mean.y = AXIS_W'(n_sum[1] >>> SAMPLE_COUNT_LOG2);
        o_mean.z = AXIS_W'(n_sum[2] >>> SAMPLE_COUNT_LOG2);
        n_cnt    = w_last ? '0 : r_cnt + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
            end
        end else if (w_acc) begin
            r_cnt <= n_cnt;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= w_last ? '0 : n_sum[a];
            end
        end
    end

endmodule

// ----- design/ascal_queue.sv -----
// Short queue of mean vectors between the front end and the math back end.
// Depends on ascal_pkg.
`timescale 1ns / 1ps
module ascal_queue import ascal_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_vec i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_vec o_data
);

    t_vec r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/ascal_back.sv -----
// Back end: offset subtract, 3x3 matrix multiply, round and saturate.
// Three-stage pipeline with per-stage valid; depends on ascal_pkg.
`timescale 1ns / 1ps
module ascal_back import ascal_pkg::*; #(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_vec i_mean,
    input  t_vec i_offset,
    input  t_mat i_matrix,
    output logic o_valid,
    input  logic i_ready,
    output t_vec o_cal,
    output logic o_clipped
);

    localparam logic signed [SUM_W-1:0] ROUND_ADD = SUM_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX   = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_MIN   = -SUM_W'(32768);

    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic signed [DIFF_W-1:0] r_diff [3];
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [AXIS_W-1:0] r_cal  [3];
    logic r_clip;

    logic signed [DIFF_W-1:0] n_diff [3];
    logic signed [PROD_W-1:0] n_prod [3][3];
    logic signed [AXIS_W-1:0] n_cal  [3];
    logic signed [SUM_W-1:0]  w_sum  [3];
    logic signed [SUM_W-1:0]  w_shift[3];
    logic [2:0] w_sat;

    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_comb begin
        n_diff[0] = DIFF_W'(i_mean.x) - DIFF_W'(i_offset.x);
        n_diff[1] = DIFF_W'(i_mean.y) - DIFF_W'(i_offset.y);
        n_diff[2] = DIFF_W'(i_mean.z) - DIFF_W'(i_offset.z);
        for (int r = 0; r < 3; r++) begin
            for (int a = 0; a < 3; a++) begin
                n_prod[r][a] = PROD_W'($signed(i_matrix[r][AXIS_W*a +: AXIS_W]))
                               * PROD_W'(r_diff[a]);
            end
        end
        for (int r = 0; r < 3; r++) begin
            w_sum[r]   = SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1])
                         + SUM_W'(r_prod[r][2]) + ROUND_ADD;
            w_shift[r] = w_sum[r] >>> COEF_FRAC_BITS;
            w_sat[r]   = 1'b1;
            if (w_shift[r] > SAT_MAX) begin
                n_cal[r] = 16'sh7FFF;
            end else if (w_shift[r] < SAT_MIN) begin
                n_cal[r] = -16'sh8000;
            end else begin
                n_cal[r] = AXIS_W'(w_shift[r]);
                w_sat[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_diff <= n_diff;
        end
        if (w_rdy2) begin
            r_prod <= n_prod;
        end
        if (w_rdy3) begin
            r_cal  <= n_cal;
            r_clip <= |w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    assign o_valid   = r_v3;
    assign o_cal.x   = r_cal[0];
    assign o_cal.y   = r_cal[1];
    assign o_cal.z   = r_cal[2];
    assign o_clipped = r_clip;

endmodule

// ----- design/averaged_sensor_calibration_apply.sv -----
// Averaged three-axis sensor calibration, top level with register file.
// Instantiates ascal_front, ascal_queue and ascal_back; depends on ascal_pkg.
//
// Takes one raw x/y/z sample per cycle while s_axis_tready is high. Every
// 2^SAMPLE_COUNT_LOG2 samples the per-axis sums are floored to a mean, the
// offset vector is subtracted and the result is multiplied by the 3x3 Q2.13
// matrix, rounded to nearest (ties up) and saturated to 16 bits; m_axis_tuser
// flags saturation. Each mean passes through a four-entry queue of means and a
// three-stage multiply pipeline, so input keeps flowing at one sample per cycle
// while the output side stalls until the queue fills. Registers are written
// through the cfg channel (always ready); the user must write them only while
// the block is idle (not enforced); index 0..2 are matrix rows, 3 the offset.
`timescale 1ns / 1ps
module averaged_sensor_calibration_apply import ascal_pkg::*; #(
    parameter int SAMPLE_COUNT_LOG2 = SAMPLE_COUNT_LOG2_DEF,
    parameter int COEF_FRAC_BITS    = COEF_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [REG_W-1:0]     s_axis_tdata,   // raw_x, raw_y, raw_z
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [REG_W-1:0]     m_axis_tdata,   // cal_x, cal_y, cal_z
    output logic                 m_axis_tuser,   // clipped
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data
);

    t_mat r_matrix;
    t_vec r_offset;
    t_vec w_raw;
    t_vec w_mean;
    t_vec w_q_data;
    t_vec w_cal;
    logic w_push;
    logic w_full;
    logic w_empty;
    logic w_back_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix[0] <= ROW0_RST;
            r_matrix[1] <= ROW1_RST;
            r_matrix[2] <= ROW2_RST;
            r_offset    <= t_vec'(OFFSET_RST);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROW0:   r_matrix[0] <= i_cfg_data;
                CFG_ROW1:   r_matrix[1] <= i_cfg_data;
                CFG_ROW2:   r_matrix[2] <= i_cfg_data;
                CFG_OFFSET: r_offset    <= t_vec'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign w_raw         = t_vec'(s_axis_tdata);
    assign s_axis_tready = !w_full;

    ascal_front #(
        .SAMPLE_COUNT_LOG2 (SAMPLE_COUNT_LOG2)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_ready (s_axis_tready),
        .i_raw   (w_raw),
        .o_push  (w_push),
        .o_mean  (w_mean)
    );

    ascal_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_mean),
        .o_full  (w_full),
        .i_pop   (w_back_ready),
        .o_empty (w_empty),
        .o_data  (w_q_data)
    );

    ascal_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (!w_empty),
        .o_ready   (w_back_ready),
        .i_mean    (w_q_data),
        .i_offset  (r_offset),
        .i_matrix  (r_matrix),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_cal     (w_cal),
        .o_clipped (m_axis_tuser)
    );

    assign m_axis_tdata = REG_W'(w_cal);

endmodule

// ----- design/ascal_checker.sv -----
// Port-level checks for averaged_sensor_calibration_apply, bound to the top.
// Depends on ascal_pkg.
`timescale 1ns / 1ps
module ascal_port_props import ascal_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [REG_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    localparam logic [AXIS_W-1:0] POS_SAT = 16'h7FFF;
    localparam logic [AXIS_W-1:0] NEG_SAT = 16'h8000;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    a_clip_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[15:0] == POS_SAT || m_axis_tdata[15:0] == NEG_SAT
            || m_axis_tdata[31:16] == POS_SAT || m_axis_tdata[31:16] == NEG_SAT
            || m_axis_tdata[47:32] == POS_SAT || m_axis_tdata[47:32] == NEG_SAT)
        else $error("clip flag without a saturated axis");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind averaged_sensor_calibration_apply ascal_port_props u_ascal_port_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/ascal_checker.sv -----
// Checker for the averaged sensor calibration block: watches the sample, result
// and register channels, predicts each calibrated vector and compares it.
// Depends on ascal_pkg.
`timescale 1ns / 1ps
module ascal_checker import ascal_pkg::*; #(
    parameter int SAMPLE_COUNT_LOG2 = SAMPLE_COUNT_LOG2_DEF,
    parameter int COEF_FRAC_BITS    = COEF_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [REG_W-1:0]     s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [REG_W-1:0]     m_axis_tdata,
    input  logic                 m_axis_tuser,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    typedef struct packed {
        logic clip;
        t_vec v;
    } t_cal;

    t_mat             cal_matrix;
    logic [REG_W-1:0] cal_offset;
    longint           axis_sum [3];
    int               samples_taken;
    t_cal             expected_cal [$];
    string            axis_name [3] = '{"cal_x", "cal_y", "cal_z"};

    function automatic t_cal calibrate_block();
        longint                  diff [3];
        longint                  acc;
        logic [2:0][AXIS_W-1:0]  axes;
        t_cal                    res;
        res.clip = 1'b0;
        for (int a = 0; a < 3; a++) begin
            diff[a] = (axis_sum[a] >>> SAMPLE_COUNT_LOG2)
                      - longint'($signed(cal_offset[a*AXIS_W +: AXIS_W]));
        end
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int a = 0; a < 3; a++) begin
                acc += longint'($signed(cal_matrix[r][a*AXIS_W +: AXIS_W])) * diff[a];
            end
            // round half up, then saturate
            acc = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            if (acc > 32767) begin
                acc = 32767;
                res.clip = 1'b1;
            end else if (acc < -32768) begin
                acc = -32768;
                res.clip = 1'b1;
            end
            axes[r] = acc[AXIS_W-1:0];
        end
        res.v = axes;
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_cal                   want;
        logic [2:0][AXIS_W-1:0] want_axes;
        logic [2:0][AXIS_W-1:0] got_axes;
        if (!i_rst_n) begin
            cal_matrix[0] = ROW0_RST;
            cal_matrix[1] = ROW1_RST;
            cal_matrix[2] = ROW2_RST;
            cal_offset    = OFFSET_RST;
            for (int a = 0; a < 3; a++) axis_sum[a] = 0;
            samples_taken = 0;
            expected_cal.delete();
            o_fail_count  = 0;
            o_checked     = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROW0:   cal_matrix[0] = i_cfg_data;
                    CFG_ROW1:   cal_matrix[1] = i_cfg_data;
                    CFG_ROW2:   cal_matrix[2] = i_cfg_data;
                    CFG_OFFSET: cal_offset    = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_cal.size() == 0) begin
                    $error("unexpected calibrated vector: tdata=%h tuser=%b",
                           m_axis_tdata, m_axis_tuser);
                    o_fail_count++;
                end else begin
                    want      = expected_cal.pop_front();
                    want_axes = want.v;
                    got_axes  = m_axis_tdata;
                    for (int a = 0; a < 3; a++) begin
                        if (got_axes[a] !== want_axes[a]) begin
                            $error("%s: expected %0d, got %0d", axis_name[a],
                                   $signed(want_axes[a]), $signed(got_axes[a]));
                            o_fail_count++;
                        end
                    end
                    if (m_axis_tuser !== want.clip) begin
                        $error("clipped: expected %0d, got %0d", want.clip, m_axis_tuser);
                        o_fail_count++;
                    end
                    o_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                for (int a = 0; a < 3; a++) begin
                    axis_sum[a] += longint'($signed(s_axis_tdata[a*AXIS_W +: AXIS_W]));
                end
                if (samples_taken + 1 < (1 << SAMPLE_COUNT_LOG2)) begin
                    samples_taken++;
                end else begin
                    expected_cal.push_back(calibrate_block());
                    for (int a = 0; a < 3; a++) axis_sum[a] = 0;
                    samples_taken = 0;
                end
            end
        end
        o_pending = expected_cal.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top for averaged_sensor_calibration_apply: clock, reset, sample and
// register stimulus with random idling, and the verdict. Checking is done by
// ascal_checker; depends on ascal_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb;
    import ascal_pkg::*;

    localparam int SAMPLES_LOG2 = SAMPLE_COUNT_LOG2_DEF;
    localparam int COEF_FRAC    = COEF_FRAC_BITS_DEF;
    localparam int BLOCK_LEN    = 1 << SAMPLES_LOG2;
    localparam int CYCLE_LIMIT  = 200000;

    // first register index with nothing behind it; 4..7 are all unused
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd4;

    localparam logic [AXIS_W-1:0] AXIS_MAX  = 16'h7FFF;
    localparam logic [AXIS_W-1:0] AXIS_MIN  = 16'h8000;
    localparam logic [AXIS_W-1:0] COEF_ONE  = 16'h2000;
    localparam logic [AXIS_W-1:0] COEF_HALF = 16'h1000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [REG_W-1:0]     s_axis_tdata;   // raw_x, raw_y, raw_z
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [REG_W-1:0]     m_axis_tdata;   // cal_x, cal_y, cal_z
    logic                 m_axis_tuser;   // clipped
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [REG_W-1:0]     i_cfg_data;

    int src_idle_pct;
    int dst_stall_pct;
    int fail_count;
    int pending;
    int checked;
    int samples_sent;
    int settings_used;
    int cycle_count;

    averaged_sensor_calibration_apply #(
        .SAMPLE_COUNT_LOG2 (SAMPLES_LOG2),
        .COEF_FRAC_BITS    (COEF_FRAC)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ascal_checker #(
        .SAMPLE_COUNT_LOG2 (SAMPLES_LOG2),
        .COEF_FRAC_BITS    (COEF_FRAC)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
    end

    function automatic t_vec vec3(input logic [AXIS_W-1:0] x, y, z);
        return {z, y, x};
    endfunction

    function automatic logic [AXIS_W-1:0] near(input logic [AXIS_W-1:0] c, input int span);
        return AXIS_W'(c + $urandom_range(0, 2 * span) - span);
    endfunction

    function automatic t_mat pick_matrix();
        t_mat                   m;
        int                     sel;
        logic [AXIS_W-1:0]      c;
        logic [2:0][AXIS_W-1:0] row;
        sel = $urandom_range(0, 9);
        for (int r = 0; r < 3; r++) begin
            for (int col = 0; col < 3; col++) begin
                if (sel == 0)      c = (r == col) ? COEF_ONE : '0;
                else if (sel == 1) c = AXIS_MAX;
                else if (sel == 2) c = AXIS_MIN;
                else if (sel == 3) c = '0;
                else if (sel < 7)  c = near((r == col) ? COEF_ONE : '0, 1024);
                else               c = AXIS_W'($urandom);
                row[col] = c;
            end
            m[r] = row;
        end
        return m;
    endfunction

    function automatic logic [REG_W-1:0] pick_offset(input t_vec centre);
        int sel;
        sel = $urandom_range(0, 4);
        case (sel)
            0: return '0;
            1: return vec3($urandom_range(1) ? AXIS_MAX : AXIS_MIN,
                           $urandom_range(1) ? AXIS_MAX : AXIS_MIN,
                           $urandom_range(1) ? AXIS_MAX : AXIS_MIN);
            2: return REG_W'({$urandom, $urandom});
            default: return vec3(near(centre.x, 512), near(centre.y, 512),
                                 near(centre.z, 512));
        endcase
    endfunction

    function automatic logic [AXIS_W-1:0] pick_axis(input logic [AXIS_W-1:0] centre, int sel);
        if (sel == 0) begin
            case ($urandom_range(0, 3))
                0: return AXIS_MAX;
                1: return AXIS_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        if (sel < 3) return AXIS_W'($urandom);
        return near(centre, 255);
    endfunction

    function automatic t_vec pick_sample(input t_vec centre);
        int sel;
        sel = $urandom_range(0, 9);
        return vec3(pick_axis(centre.x, sel), pick_axis(centre.y, sel),
                    pick_axis(centre.z, sel));
    endfunction

    task automatic send_sample(input t_vec v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        samples_sent++;
    endtask

    // leaves valid high so writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_setting(input t_mat rows, input logic [REG_W-1:0] offs);
        write_reg(CFG_ROW0, rows[0]);
        write_reg(CFG_ROW1, rows[1]);
        write_reg(CFG_ROW2, rows[2]);
        write_reg(CFG_OFFSET, offs);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_IDX_W'(CFG_IDX_UNUSED + $urandom_range(0, 3)),
                      REG_W'({$urandom, $urandom}));
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain_results();
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        t_vec centre;
        int   n_items;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_ROW0;
        i_cfg_data    = '0;
        src_idle_pct  = 8;
        dst_stall_pct = 77;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset setting: full-scale means, and a negative mean that floors
        for (int i = 0; i < BLOCK_LEN; i++) begin
            send_sample(vec3(AXIS_MAX, AXIS_MIN, (i % 2) ? -16'sd2 : 16'sd1));
        end
        s_axis_tvalid <= 1'b0;
        drain_results();

        // extreme coefficients and offset: both saturation directions, a tie
        write_reg(CFG_IDX_UNUSED + 3'd3, '1);
        load_setting({vec3('0, '0, COEF_HALF), vec3(AXIS_MIN, AXIS_MIN, AXIS_MIN),
                      vec3(AXIS_MAX, AXIS_MAX, AXIS_MAX)},
                     vec3(AXIS_MIN, '0, '0));
        for (int i = 0; i < BLOCK_LEN; i++) send_sample(vec3(AXIS_MAX, AXIS_MAX, -16'sd3));
        s_axis_tvalid <= 1'b0;
        drain_results();

        // widest negative difference, identity rows for x and y, half-scale z row
        load_setting({vec3('0, '0, COEF_HALF), ROW1_RST, ROW0_RST},
                     vec3(AXIS_MAX, AXIS_MAX, AXIS_MAX));
        for (int i = 0; i < BLOCK_LEN; i++) send_sample(vec3(AXIS_MIN, AXIS_MIN, AXIS_MIN));
        s_axis_tvalid <= 1'b0;
        drain_results();

        for (int pass = 0; pass < 3; pass++) begin
            src_idle_pct  = (pass == 0) ? 8 : (pass == 1) ? 77 : 0;
            dst_stall_pct = (pass == 0) ? 77 : (pass == 1) ? 8 : 0;
            for (int ph = 0; ph < 6; ph++) begin
                drain_results();
                centre  = vec3(AXIS_W'($urandom_range(0, 32767) - 16384),
                               AXIS_W'($urandom_range(0, 32767) - 16384),
                               AXIS_W'($urandom_range(0, 32767) - 16384));
                load_setting(pick_matrix(), pick_offset(centre));
                n_items = $urandom_range(80, 115);
                for (int i = 0; i < n_items; i++) send_sample(pick_sample(centre));
                s_axis_tvalid <= 1'b0;
            end
        end

        drain_results();
        $display("Covered %0d raw samples under %0d register settings, %0d vectors checked",
                 samples_sent, settings_used, checked);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
